// ===== src/apg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apg_pkg: shared types and constants for the auto-pan LFO gain stage
// Holds the sample and phase widths, the register indexes, the waveform codes
// and the payload structs of the input and output channels.
// ----------------------------------------------------------------------------
package apg_pkg;

	// Fixed field widths.
	localparam int SAMPLE_BITS = 16;
	localparam int PHASE_BITS  = 32;
	localparam int LEVEL_BITS  = 16;
	localparam int STEP_BITS   = 31;
	localparam int DEPTH_BITS  = 16;
	localparam int CFG_BITS    = 32;
	localparam int IDX_BITS    = 2;

	// Gain is carried in Q1.31, one is 2^31.
	localparam int GAIN_BITS   = 32;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE = 32'h8000_0000;

	// Depth saturates at 1.0 in Q1.15.
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = 16'h8000;

	// Register reset values.
	localparam logic [STEP_BITS-1:0]  STEP_RESET   = 31'd89478;
	localparam logic [DEPTH_BITS-1:0] DEPTH_RESET  = 16'h8000;
	localparam logic [PHASE_BITS-1:0] OFFSET_RESET = 32'h0000_0000;

	// Register indexes on the configuration port.
	localparam logic [IDX_BITS-1:0] REG_STEP   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_DEPTH  = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_WAVE   = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_OFFSET = 2'd3;

	// LFO waveform codes.
	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_SAW      = 2'd3
	} wave_t;

	// Input transaction payload.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} in_t;

	// Output transaction payload.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_t;

endpackage
`default_nettype wire

// ===== src/apg_level.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apg_level: LFO waveform generator
// Turns a phase into a unipolar level in Q0.16 for the selected waveform.
// The sine comes from a quarter-wave table built at elaboration.
// ----------------------------------------------------------------------------
module apg_level import apg_pkg::*; #(
	parameter int TABLE_BITS = 8
) (
	input  wire logic [PHASE_BITS-1:0] phase,
	input  wire wave_t                 wave,
	output logic      [LEVEL_BITS-1:0] level
);

	localparam int TBL_N = 1 << TABLE_BITS;
	localparam logic [TABLE_BITS:0] TBL_N_W = (TABLE_BITS+1)'(TBL_N);

	// Quarter sine entry round(32767*sin(pi/2*k/N)) from a Taylor series in Q2.30.
	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		x    = (64'd1686629713 * 64'(k)) >> tb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum  = (sum >= term) ? sum - term : 64'd0;
		q    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[14:0];
	endfunction

	// Constant quarter-wave table, N+1 entries.
	logic [14:0] rom [0:TBL_N];

	for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
		localparam logic [14:0] QV = sine_entry(k, TABLE_BITS);
		assign rom[k] = QV;
	end

	logic [LEVEL_BITS-1:0] p;
	logic [1:0]            quad;
	logic [TABLE_BITS-1:0] frac;
	logic [TABLE_BITS:0]   idx;
	logic [14:0]           qv;
	logic [LEVEL_BITS-1:0] neg_p;
	logic [LEVEL_BITS-1:0] sine_u;
	logic [LEVEL_BITS-1:0] tri_u;

	assign p     = phase[PHASE_BITS-1 -: LEVEL_BITS];
	assign quad  = phase[PHASE_BITS-1 -: 2];
	assign frac  = phase[PHASE_BITS-3 -: TABLE_BITS];
	assign neg_p = LEVEL_BITS'(0) - p;

	// Sine: mirror the index in odd quadrants, negate in the second half.
	always_comb begin
		idx    = quad[0] ? (TBL_N_W - {1'b0, frac}) : {1'b0, frac};
		qv     = rom[idx];
		sine_u = quad[1] ? (16'h8000 - {1'b0, qv}) : (16'h8000 + {1'b0, qv});
	end

	// Triangle: the peak at half a cycle saturates to full scale.
	always_comb begin
		if (!p[LEVEL_BITS-1]) begin
			tri_u = {p[LEVEL_BITS-2:0], 1'b0};
		end else if (p == 16'h8000) begin
			tri_u = 16'hFFFF;
		end else begin
			tri_u = {neg_p[LEVEL_BITS-2:0], 1'b0};
		end
	end

	// Waveform select.
	always_comb begin
		case (wave)
			WAVE_SINE:     level = sine_u;
			WAVE_TRIANGLE: level = tri_u;
			WAVE_SQUARE:   level = p[LEVEL_BITS-1] ? 16'h0000 : 16'hFFFF;
			WAVE_SAW:      level = p;
			default:       level = p;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/auto_pan_lfo_gain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auto_pan_lfo_gain: stereo auto-pan gain stage driven by an LFO
// Scales each left/right sample pair by a gain of 1 - level*depth, where the
// level comes from a phase accumulator and a selectable waveform.
// ----------------------------------------------------------------------------
// Each accepted stereo pair passes an accept step that advances the phase, then
// three steps per channel (waveform lookup, gain, scaling), with both channels
// passing in turn through one shared 17 x 33 bit multiplier that computes
// first level*depth and then sample*gain. The input is ready again
// once the right channel result has been loaded into the output register; that
// register holds the finished pair until it is taken, so the next pair can be
// accepted meanwhile. The phase advances before the first pair is scaled and
// is cleared by reset. Configuration writes take effect at once and should be
// made while no pair is in flight.
// ----------------------------------------------------------------------------
module auto_pan_lfo_gain import apg_pkg::*; #(
	parameter int SINE_TABLE_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration write port
	input  wire logic                cfg_we,
	input  wire logic [IDX_BITS-1:0] cfg_idx,
	input  wire logic [CFG_BITS-1:0] cfg_data,
	// Input channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_t                 in_data,
	// Output channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_t                     out_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LEVEL = 4'b0010,
		S_GAIN  = 4'b0100,
		S_SCALE = 4'b1000
	} state_t;

	localparam int MUL_A_BITS = SAMPLE_BITS + 1;
	localparam int MUL_B_BITS = GAIN_BITS + 1;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	state_t                   state_q;
	logic                     chan_q;
	logic [STEP_BITS-1:0]     step_q;
	logic [DEPTH_BITS-1:0]    depth_q;
	wave_t                    wave_q;
	logic [PHASE_BITS-1:0]    offset_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [PHASE_BITS-1:0]    rphase_q;
	in_t                      in_q;
	logic [LEVEL_BITS-1:0]    level_q;
	logic [GAIN_BITS-1:0]     gain_q;
	logic [SAMPLE_BITS-1:0]   left_res_q;
	out_t                     out_q;
	logic                     out_valid_q;

	logic                     in_fire;
	logic                     out_free;
	logic [PHASE_BITS-1:0]    lvl_phase;
	logic [LEVEL_BITS-1:0]    lvl;
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [PROD_BITS-1:0]  prod;
	logic [SAMPLE_BITS-1:0]   scaled;
	logic                     last_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_fire = (state_q == S_SCALE) && chan_q && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers; depth is stored already saturated at one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RESET;
			depth_q  <= DEPTH_RESET;
			wave_q   <= WAVE_SINE;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_STEP:   step_q   <= cfg_data[STEP_BITS-1:0];
				REG_DEPTH:  depth_q  <= (cfg_data[DEPTH_BITS-1:0] > DEPTH_MAX) ?
					DEPTH_MAX : cfg_data[DEPTH_BITS-1:0];
				REG_WAVE:   wave_q   <= wave_t'(cfg_data[1:0]);
				REG_OFFSET: offset_q <= cfg_data[PHASE_BITS-1:0];
				default:    step_q   <= step_q;
			endcase
		end
	end

	// Waveform lookup for the channel being processed.
	assign lvl_phase = chan_q ? rphase_q : phase_q;

	apg_level #(
		.TABLE_BITS (SINE_TABLE_BITS)
	) u_level (
		.phase (lvl_phase),
		.wave  (wave_q),
		.level (lvl)
	);

	// Shared multiplier: level*depth in the gain step, sample*gain when scaling.
	always_comb begin
		if (state_q == S_GAIN) begin
			mul_a = MUL_A_BITS'({1'b0, level_q});
			mul_b = MUL_B_BITS'({1'b0, depth_q});
		end else begin
			mul_a = MUL_A_BITS'(chan_q ? in_q.right_in : in_q.left_in);
			mul_b = MUL_B_BITS'({1'b0, gain_q});
		end
		prod   = mul_a * mul_b;
		scaled = prod[GAIN_BITS-1 +: SAMPLE_BITS];
	end

	// Sequencer and phase accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						phase_q <= phase_q + PHASE_BITS'(step_q);
						state_q <= S_LEVEL;
					end
				end
				S_LEVEL: state_q <= S_GAIN;
				S_GAIN:  state_q <= S_SCALE;
				S_SCALE: begin
					if (!chan_q) begin
						chan_q  <= 1'b1;
						state_q <= S_LEVEL;
					end else if (out_free) begin
						chan_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					chan_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_data;
		end
		if (state_q == S_LEVEL) begin
			level_q <= lvl;
			if (!chan_q) begin
				rphase_q <= phase_q + offset_q;
			end
		end
		if (state_q == S_GAIN) begin
			gain_q <= GAIN_ONE - prod[GAIN_BITS-1:0];
		end
		if ((state_q == S_SCALE) && !chan_q) begin
			left_res_q <= scaled;
		end
		if (last_fire) begin
			out_q.left_out  <= left_res_q;
			out_q.right_out <= scaled;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The phase advances by exactly one step per accepted transaction.
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> phase_q == $past(phase_q) + PHASE_BITS'($past(step_q)))
		else $error("phase did not advance by one step");

	// The gain is always positive and at most one when a sample is scaled.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE) |-> (gain_q != '0) && (gain_q <= GAIN_ONE))
		else $error("gain out of range");

	// A new result appears only after the right channel has been scaled.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SCALE) && $past(chan_q))
		else $error("output loaded outside the final scaling step");

	// Each transaction starts on the left channel.
	a_idle_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !chan_q)
		else $error("channel select not cleared when idle");

	// Stored depth never exceeds one.
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("depth above full scale");

endmodule
`default_nettype wire

// ===== dv/tb_auto_pan_lfo_gain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_auto_pan_lfo_gain: self-checking testbench for the auto-pan LFO gain stage
// Walks a table of directed register writes and stereo pairs, then runs
// phases of random settings and random pairs with random idling on both
// channels. Every output transaction is checked against a model of the phase
// accumulator, the four waveforms and the gain scaling kept in this bench.
// ----------------------------------------------------------------------------
module tb_auto_pan_lfo_gain;
	import apg_pkg::*;

	localparam int ROM_ADDR_BITS = 8;
	localparam int ROM_N         = 1 << ROM_ADDR_BITS;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int NUM_PHASES    = 12;
	localparam int PHASE_PAIRS   = 94;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;

	// One row of the directed table: a register write or a stereo pair,
	// optionally with the result written out by hand.
	typedef struct {
		row_kind_t             kind;
		logic [IDX_BITS-1:0]   idx;
		logic [CFG_BITS-1:0]   val;
		logic [SAMPLE_BITS-1:0] l;
		logic [SAMPLE_BITS-1:0] r;
		bit                    known;
		logic [SAMPLE_BITS-1:0] el;
		logic [SAMPLE_BITS-1:0] er;
	} row_t;

	localparam int PLAN_ROWS = 38;

	row_t plan [PLAN_ROWS] = '{
		// Defaults after reset.
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h7FFF, 1'b0, 16'h0,    16'h0},
		// Zero depth passes the samples unchanged.
		'{ROW_WRITE, REG_DEPTH,  32'h0,            16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h5555, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA},
		// Square wave, depth above one, frozen phase, right half a cycle ahead.
		'{ROW_WRITE, REG_WAVE,   32'(WAVE_SQUARE), 16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_DEPTH,  32'h0000_FFFF,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_STEP,   32'h0,            16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_OFFSET, 32'h8000_0000,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h7FFF, 1'b1, 16'h0000, 16'h7FFF},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h8000, 1'b1, 16'hFFFF, 16'h8000},
		// Land exactly on the triangle peak, which saturates.
		'{ROW_WRITE, REG_STEP,   32'h7FF9_2C62,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_WAVE,   32'(WAVE_TRIANGLE), 16'h0,  16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_OFFSET, 32'h0,            16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'hFFFF},
		// Saw with the largest step and offset.
		'{ROW_WRITE, REG_STEP,   32'h7FFF_FFFF,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_WAVE,   32'(WAVE_SAW),    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_OFFSET, 32'hFFFF_FFFF,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h7FFF, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'hFFFF, 16'h0001, 1'b0, 16'h0,    16'h0},
		// Sine through all quadrants; the step has its unused top bit set.
		'{ROW_WRITE, REG_WAVE,   32'(WAVE_SINE),   16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_STEP,   32'h9300_0000,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_DEPTH,  32'h0000_4000,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_WRITE, REG_OFFSET, 32'h4000_0000,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h1234, 16'hEDCB, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h7FFF, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h0FF0, 16'hF00F, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h5A5A, 16'hA5A5, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h7FFF, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h8000, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h0001, 16'hFFFF, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h3333, 16'hCCCC, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'hC000, 16'h4000, 1'b0, 16'h0,    16'h0},
		'{ROW_PAIR,  REG_STEP,   32'h0,            16'h8000, 16'h7FFF, 1'b0, 16'h0,    16'h0}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [IDX_BITS-1:0] cfg_idx   = '0;
	logic [CFG_BITS-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_t                 in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_t                out_data;

	// Mirror of the registers and the phase accumulator.
	logic [STEP_BITS-1:0]  step_cfg   = STEP_RESET;
	logic [DEPTH_BITS-1:0] depth_cfg  = DEPTH_RESET;
	wave_t                 wave_cfg   = WAVE_SINE;
	logic [PHASE_BITS-1:0] offset_cfg = OFFSET_RESET;
	logic [PHASE_BITS-1:0] lfo_acc    = '0;
	int unsigned           sine_q [0:ROM_N];

	out_t pending_pairs [$];
	int   fault_count = 0;
	int   cycle_count = 0;
	bit   tx_idle     = 1'b0;
	bit   rx_idle     = 1'b0;
	bit   hold_req    = 1'b0;

	auto_pan_lfo_gain i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Reset is held low at the start and released on a rising clock edge.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Unipolar LFO level in Q0.16 for one phase under the current waveform.
	function automatic logic [LEVEL_BITS-1:0] lfo_level(logic [PHASE_BITS-1:0] ph);
		int unsigned u;
		int unsigned p;
		int unsigned f;
		int unsigned q;
		p = 32'(ph[PHASE_BITS-1 -: 16]);
		case (wave_cfg)
			WAVE_SINE: begin
				f = 32'(ph[PHASE_BITS-3 -: ROM_ADDR_BITS]);
				q = sine_q[ph[PHASE_BITS-2] ? ROM_N - f : f];
				u = ph[PHASE_BITS-1] ? 32768 - q : 32768 + q;
			end
			WAVE_TRIANGLE: u = (p < 32768) ? 2 * p : 2 * (65536 - p);
			WAVE_SQUARE:   u = (p < 32768) ? 65535 : 0;
			default:       u = p;
		endcase
		if (u > 65535)
			u = 65535;
		return u[LEVEL_BITS-1:0];
	endfunction

	// Scale one sample by 1 - level*depth and drop the fraction (floor).
	function automatic logic [SAMPLE_BITS-1:0] gain_scaled(logic [SAMPLE_BITS-1:0] s,
			logic [LEVEL_BITS-1:0] lvl);
		logic [DEPTH_BITS-1:0] d;
		longint gain;
		longint prod;
		d = (depth_cfg > DEPTH_MAX) ? DEPTH_MAX : depth_cfg;
		gain = (longint'(1) << 31) - longint'(lvl) * longint'(d);
		prod = longint'($signed(s)) * gain;
		prod = prod >>> 31;
		return prod[SAMPLE_BITS-1:0];
	endfunction

	// Advance the phase, then work out the scaled pair for one transaction.
	function automatic out_t pan_step(in_t d);
		out_t                  res;
		logic [PHASE_BITS-1:0] rph;
		lfo_acc = lfo_acc + {1'b0, step_cfg};
		rph = lfo_acc + offset_cfg;
		res.left_out  = gain_scaled(d.left_in, lfo_level(lfo_acc));
		res.right_out = gain_scaled(d.right_in, lfo_level(rph));
		return res;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Write one register and keep the mirror in step. The enable stays high;
	// the caller lowers it after the last write of a group.
	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		case (idx)
			REG_STEP:   step_cfg   = val[STEP_BITS-1:0];
			REG_DEPTH:  depth_cfg  = val[DEPTH_BITS-1:0];
			REG_WAVE:   wave_cfg   = wave_t'(val[1:0]);
			REG_OFFSET: offset_cfg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one pair and hold it until accepted, then queue its result.
	task automatic send_pair(input in_t d, input bit known, input out_t known_res);
		out_t predicted;
		in_valid <= 1'b1;
		in_data  <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = pan_step(d);
		pending_pairs.push_back(known ? known_res : predicted);
	endtask

	// Wait until every queued result has come out and the pipeline is empty.
	task automatic settle();
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// Output channel: random stall bursts, plus one long hold-off on request.
	initial begin
		int k;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each output transaction with the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pairs.size() == 0) begin
				note_fault($sformatf("unexpected output %h/%h",
					out_data.left_out, out_data.right_out));
			end else begin
				want = pending_pairs.pop_front();
				if (out_data.left_out !== want.left_out)
					note_fault($sformatf("left_out expected %h got %h",
						want.left_out, out_data.left_out));
				if (out_data.right_out !== want.right_out)
					note_fault($sformatf("right_out expected %h got %h",
						want.right_out, out_data.right_out));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		longint unsigned x, x2, term, acc, q, t;
		int   i, ph, n;
		bit   last;
		in_t  pair;
		out_t known_res;
		logic [CFG_BITS-1:0] val;

		// Quarter-wave sine table by integer Taylor series in Q2.30.
		for (i = 0; i <= ROM_N; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) >> ROM_ADDR_BITS;
			x2 = (x * x) >> 30;
			term = x;
			acc = x;
			for (t = 1; t < 14; t += 2) begin
				term = ((term * x2) >> 30) / ((t + 1) * (t + 2));
				if (((t + 1) / 2) & 1)
					acc = (acc >= term) ? acc - term : 0;
				else
					acc = acc + term;
			end
			q = (acc * 32767 + (64'd1 << 29)) >> 30;
			sine_q[i] = (q > 32767) ? 32767 : int'(q);
		end

		wait (arst_n);
		@(posedge clk);

		// Directed table.
		for (i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (i > 0 && plan[i-1].kind == ROW_PAIR) begin
					in_valid <= 1'b0;
					settle();
				end
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				cfg_we <= 1'b0;
				pair.left_in       = plan[i].l;
				pair.right_in      = plan[i].r;
				known_res.left_out  = plan[i].el;
				known_res.right_out = plan[i].er;
				send_pair(pair, plan[i].known, known_res);
			end
		end
		in_valid <= 1'b0;

		// Random phases, each with fresh settings written while idle.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			last = (ph == NUM_PHASES - 1);
			settle();

			case ($urandom_range(0, 4))
				0:       val = 32'h0;
				1:       val = 32'h7FFF_FFFF;
				2:       val = $urandom_range(1, 32'h0010_0000);
				3:       val = $urandom();
				default: val = $urandom_range(0, 32'h0100_0000);
			endcase
			write_reg(REG_STEP, val);

			case ($urandom_range(0, 4))
				0:       val = 32'h0;
				1:       val = 32'(DEPTH_MAX);
				2:       val = 32'h0000_FFFF;
				3:       val = $urandom_range(32769, 65535);
				default: val = $urandom_range(0, 32768);
			endcase
			// Upper bits beyond the register width are ignored.
			if ($urandom_range(0, 3) == 0)
				val = val | ($urandom() & 32'hFFFF_0000);
			write_reg(REG_DEPTH, val);

			val = ($urandom() & 32'hFFFF_FFFC) | 32'(wave_t'(ph % 4));
			write_reg(REG_WAVE, val);

			case ($urandom_range(0, 4))
				0:       val = 32'h0;
				1:       val = 32'hFFFF_FFFF;
				2:       val = 32'h8000_0000;
				default: val = $urandom();
			endcase
			write_reg(REG_OFFSET, val);
			cfg_we <= 1'b0;

			tx_idle = !last && ($urandom_range(0, 3) != 0);
			rx_idle = !last && ($urandom_range(0, 3) != 0);
			// The first phase starts with a long output stall to back up the input.
			if (ph == 0)
				hold_req = 1'b1;

			for (n = 0; n < PHASE_PAIRS; n++) begin
				pair.left_in  = random_sample();
				pair.right_in = random_sample();
				send_pair(pair, 1'b0, '0);
				if (tx_idle && $urandom_range(0, 5) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 11)) @(posedge clk);
				end
			end
			in_valid <= 1'b0;
		end

		settle();
		if (fault_count == 0 && pending_pairs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
